[rtl/sawa_pkg.sv]
// Shared types, codes and CRC-4 tables for the stop-and-wait ARQ endpoint.
`default_nettype none

package sawa_pkg;

  localparam int SEQ_BITS      = 8;
  localparam int PAYLOAD_BYTES = 3;
  localparam int PL_BITS       = 8 * PAYLOAD_BYTES;
  localparam int TYPE_BITS     = 2;
  localparam int CRC_BITS      = 4;
  localparam int FIELD_BITS    = 32;
  localparam int FRAME_BITS    = 3 * FIELD_BITS + PL_BITS;

  // Generator x^4 + x^2 + 1 without its leading term.
  localparam logic [CRC_BITS-1:0] CRC_POLY = 4'h5;

  // Fill payloads for NACK ("nnn") and duplicate acknowledgement ("ign") frames.
  localparam logic [PL_BITS-1:0] PL_NAK = {PAYLOAD_BYTES{8'h6e}};
  localparam logic [PL_BITS-1:0] PL_IGN = 24'h69676e;

  typedef enum logic [1:0] {
    FUNC_SEND  = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_TIMER = 2'd2
  } func_e;

  typedef enum logic [TYPE_BITS-1:0] {
    FT_DATA  = 2'd0,
    FT_ACK   = 2'd1,
    FT_PIGGY = 2'd2
  } ftype_e;

  typedef enum logic [1:0] {
    TMR_NONE  = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } timer_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [PL_BITS-1:0]   payload;
    logic [TYPE_BITS-1:0] frame_type;
    logic [SEQ_BITS-1:0]  frame_seq;
    logic [SEQ_BITS-1:0]  frame_ack;
    logic [CRC_BITS-1:0]  frame_crc;
  } item_t;

  typedef struct packed {
    logic                 tx_valid;
    logic [TYPE_BITS-1:0] tx_type;
    logic [SEQ_BITS-1:0]  tx_seq;
    logic [SEQ_BITS-1:0]  tx_ack;
    logic [PL_BITS-1:0]   tx_payload;
    logic [CRC_BITS-1:0]  tx_crc;
    logic                 deliver_valid;
    logic [PL_BITS-1:0]   deliver_payload;
    logic                 send_refused;
    logic [1:0]           timer_cmd;
  } result_t;

  // Remainder contributed by a single one bit followed by k zero bits, for every k.
  // The CRC is linear, so the remainder of a frame is the XOR of these over its set bits.
  function automatic logic [CRC_BITS*FRAME_BITS-1:0] crc_weights();
    logic [CRC_BITS*FRAME_BITS-1:0] tab;
    logic [CRC_BITS-1:0]            r;
    logic                           top;
    tab = '0;
    r   = CRC_POLY;
    for (int k = 0; k < FRAME_BITS; k++) begin
      tab[CRC_BITS*k +: CRC_BITS] = r;
      top = r[CRC_BITS-1];
      r   = {r[CRC_BITS-2:0], 1'b0} ^ (top ? CRC_POLY : '0);
    end
    return tab;
  endfunction

  localparam logic [CRC_BITS*FRAME_BITS-1:0] CRC_WEIGHTS = crc_weights();

endpackage

`default_nettype wire

[rtl/sawa_if.sv]
// Valid/ready channel interfaces for event input and result output.
`default_nettype none

interface sawa_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic [sawa_pkg::PL_BITS-1:0]   payload;
  logic [sawa_pkg::TYPE_BITS-1:0] frame_type;
  logic [sawa_pkg::SEQ_BITS-1:0]  frame_seq;
  logic [sawa_pkg::SEQ_BITS-1:0]  frame_ack;
  logic [sawa_pkg::CRC_BITS-1:0]  frame_crc;

  modport source (output valid, func, payload, frame_type, frame_seq, frame_ack, frame_crc,
                  input ready);
  modport sink   (input valid, func, payload, frame_type, frame_seq, frame_ack, frame_crc,
                  output ready);
endinterface

interface sawa_out_if;
  logic                           valid;
  logic                           ready;
  logic                           tx_valid;
  logic [sawa_pkg::TYPE_BITS-1:0] tx_type;
  logic [sawa_pkg::SEQ_BITS-1:0]  tx_seq;
  logic [sawa_pkg::SEQ_BITS-1:0]  tx_ack;
  logic [sawa_pkg::PL_BITS-1:0]   tx_payload;
  logic [sawa_pkg::CRC_BITS-1:0]  tx_crc;
  logic                           deliver_valid;
  logic [sawa_pkg::PL_BITS-1:0]   deliver_payload;
  logic                           send_refused;
  logic [1:0]                     timer_cmd;

  modport source (output valid, tx_valid, tx_type, tx_seq, tx_ack, tx_payload, tx_crc,
                  deliver_valid, deliver_payload, send_refused, timer_cmd,
                  input ready);
  modport sink   (input valid, tx_valid, tx_type, tx_seq, tx_ack, tx_payload, tx_crc,
                  deliver_valid, deliver_payload, send_refused, timer_cmd,
                  output ready);
endinterface

`default_nettype wire

[rtl/stop_and_wait_arq_endpoint.sv]
// Stop-and-wait ARQ endpoint with piggybacked acknowledgements and CRC-4 framing.
//
// Events arrive on in_i: a send request from the upper layer, a frame from the
// link or a retransmit timer expiry. Each event yields exactly one result on
// out_o, carrying an optional frame for the link, an optional payload for the
// upper layer, a refusal flag and a command for the external retransmit timer.
//
// An event is held in the input register and decided there, with its CRC checks,
// against the protocol state; the result goes to the output register, from which
// it is offered on out_o. One event can be taken every cycle while the receiver
// does not stall, set by the single decision stage.
//
// When the receiver stalls, the result is held in the output register and the
// next event waits in the input register; in_i.ready falls only once both are
// full. Reset empties both registers, sets the endpoint ready to send with send
// and receive sequence numbers at zero, nothing received and no ack pending.
`default_nettype none

module stop_and_wait_arq_endpoint (
  input  logic       clk_i,
  input  logic       rst_ni,
  sawa_in_if.sink    in_i,
  sawa_out_if.source out_o
);

  logic              in_valid_q;
  sawa_pkg::item_t   item_q;
  logic              out_valid_q;
  sawa_pkg::result_t res_q;
  sawa_pkg::result_t res_c;
  logic              advance;
  logic              in_xfer;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  sawa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .res_o  (res_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.func       <= in_i.func;
      item_q.payload    <= in_i.payload;
      item_q.frame_type <= in_i.frame_type;
      item_q.frame_seq  <= in_i.frame_seq;
      item_q.frame_ack  <= in_i.frame_ack;
      item_q.frame_crc  <= in_i.frame_crc;
    end
    if (advance) begin
      res_q <= res_c;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.tx_valid        = res_q.tx_valid;
  assign out_o.tx_type         = res_q.tx_type;
  assign out_o.tx_seq          = res_q.tx_seq;
  assign out_o.tx_ack          = res_q.tx_ack;
  assign out_o.tx_payload      = res_q.tx_payload;
  assign out_o.tx_crc          = res_q.tx_crc;
  assign out_o.deliver_valid   = res_q.deliver_valid;
  assign out_o.deliver_payload = res_q.deliver_payload;
  assign out_o.send_refused    = res_q.send_refused;
  assign out_o.timer_cmd       = res_q.timer_cmd;

endmodule

`default_nettype wire

[rtl/sawa_crc4.sv]
// CRC-4 XOR tree over the ack, seq, type and payload fields of one frame.
`default_nettype none

module sawa_crc4 (
  input  logic [sawa_pkg::SEQ_BITS-1:0]  ack_i,
  input  logic [sawa_pkg::SEQ_BITS-1:0]  seq_i,
  input  logic [sawa_pkg::TYPE_BITS-1:0] type_i,
  input  logic [sawa_pkg::PL_BITS-1:0]   payload_i,
  output logic [sawa_pkg::CRC_BITS-1:0]  crc_o
);

  logic [sawa_pkg::FRAME_BITS-1:0] msg;

  // The ack, seq and type fields travel zero-extended to 32 bits, ack first, then the 24-bit payload.
  assign msg = {{(sawa_pkg::FIELD_BITS - sawa_pkg::SEQ_BITS){1'b0}}, ack_i,
                {(sawa_pkg::FIELD_BITS - sawa_pkg::SEQ_BITS){1'b0}}, seq_i,
                {(sawa_pkg::FIELD_BITS - sawa_pkg::TYPE_BITS){1'b0}}, type_i,
                payload_i};

  always_comb begin
    crc_o = '0;
    for (int i = 0; i < sawa_pkg::FRAME_BITS; i++) begin
      if (msg[i]) begin
        crc_o = crc_o ^ sawa_pkg::CRC_WEIGHTS[sawa_pkg::CRC_BITS*i +: sawa_pkg::CRC_BITS];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sawa_ctrl.sv]
// Protocol state and per-event decision logic of the ARQ endpoint.
`default_nettype none

module sawa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  sawa_pkg::item_t   item_i,
  output sawa_pkg::result_t res_o
);

  logic [sawa_pkg::SEQ_BITS-1:0] send_seq_q, send_seq_d;
  logic [sawa_pkg::SEQ_BITS-1:0] last_rx_seq_q, last_rx_seq_d;
  logic                          have_rx_q, have_rx_d;
  logic                          ready_q, ready_d;
  logic                          ack_pending_q, ack_pending_d;
  logic [sawa_pkg::PL_BITS-1:0]  saved_payload_q, saved_payload_d;
  logic [sawa_pkg::SEQ_BITS-1:0] saved_seq_q, saved_seq_d;

  logic [sawa_pkg::CRC_BITS-1:0] rx_crc;
  logic [sawa_pkg::CRC_BITS-1:0] tx_crc;
  sawa_pkg::result_t             res_c;
  logic                          ack_match;

  sawa_crc4 u_rx_crc (
    .ack_i     (item_i.frame_ack),
    .seq_i     (item_i.frame_seq),
    .type_i    (item_i.frame_type),
    .payload_i (item_i.payload),
    .crc_o     (rx_crc)
  );

  // Unused transmit fields stay zero, and an all-zero frame has a zero remainder.
  sawa_crc4 u_tx_crc (
    .ack_i     (res_c.tx_ack),
    .seq_i     (res_c.tx_seq),
    .type_i    (res_c.tx_type),
    .payload_i (res_c.tx_payload),
    .crc_o     (tx_crc)
  );

  assign ack_match = (item_i.frame_ack == send_seq_q);

  always_comb begin
    res_c           = '0;
    send_seq_d      = send_seq_q;
    last_rx_seq_d   = last_rx_seq_q;
    have_rx_d       = have_rx_q;
    ready_d         = ready_q;
    ack_pending_d   = ack_pending_q;
    saved_payload_d = saved_payload_q;
    saved_seq_d     = saved_seq_q;

    unique case (sawa_pkg::func_e'(item_i.func))
      sawa_pkg::FUNC_SEND: begin
        if (ready_q) begin
          res_c.tx_valid   = 1'b1;
          res_c.tx_type    = ack_pending_q ? sawa_pkg::FT_PIGGY : sawa_pkg::FT_DATA;
          res_c.tx_seq     = send_seq_q;
          res_c.tx_ack     = ack_pending_q ? last_rx_seq_q : '0;
          res_c.tx_payload = item_i.payload;
          res_c.timer_cmd  = sawa_pkg::TMR_START;
          saved_payload_d  = item_i.payload;
          saved_seq_d      = send_seq_q;
          ready_d          = 1'b0;
          ack_pending_d    = 1'b0;
        end else begin
          res_c.send_refused = 1'b1;
        end
      end
      sawa_pkg::FUNC_FRAME: begin
        if (rx_crc != item_i.frame_crc) begin
          res_c.tx_valid   = 1'b1;
          res_c.tx_type    = sawa_pkg::FT_ACK;
          res_c.tx_ack     = have_rx_q ? last_rx_seq_q : '0;
          res_c.tx_payload = sawa_pkg::PL_NAK;
        end else if (item_i.frame_type == sawa_pkg::FT_DATA ||
                     (item_i.frame_type == sawa_pkg::FT_PIGGY && ack_match)) begin
          // A piggybacked frame with a matching ack first takes the ack, then its data.
          if (item_i.frame_type == sawa_pkg::FT_PIGGY) begin
            ready_d         = 1'b1;
            send_seq_d      = send_seq_q + 1'b1;
            res_c.timer_cmd = sawa_pkg::TMR_STOP;
          end
          ack_pending_d = 1'b1;
          if (have_rx_q && item_i.frame_seq == last_rx_seq_q) begin
            res_c.tx_valid   = 1'b1;
            res_c.tx_type    = sawa_pkg::FT_ACK;
            res_c.tx_ack     = last_rx_seq_q;
            res_c.tx_payload = sawa_pkg::PL_IGN;
          end else begin
            last_rx_seq_d         = item_i.frame_seq;
            have_rx_d             = 1'b1;
            res_c.deliver_valid   = 1'b1;
            res_c.deliver_payload = item_i.payload;
          end
        end else if (item_i.frame_type == sawa_pkg::FT_ACK && ack_match) begin
          ready_d         = 1'b1;
          ack_pending_d   = 1'b0;
          send_seq_d      = send_seq_q + 1'b1;
          res_c.timer_cmd = sawa_pkg::TMR_STOP;
        end
      end
      sawa_pkg::FUNC_TIMER: begin
        if (!ready_q) begin
          res_c.tx_valid   = 1'b1;
          res_c.tx_type    = ack_pending_q ? sawa_pkg::FT_PIGGY : sawa_pkg::FT_DATA;
          res_c.tx_seq     = saved_seq_q;
          res_c.tx_ack     = ack_pending_q ? last_rx_seq_q : '0;
          res_c.tx_payload = saved_payload_q;
          res_c.timer_cmd  = sawa_pkg::TMR_START;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o        = res_c;
    res_o.tx_crc = tx_crc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_seq_q      <= '0;
      last_rx_seq_q   <= '0;
      have_rx_q       <= 1'b0;
      ready_q         <= 1'b1;
      ack_pending_q   <= 1'b0;
      saved_payload_q <= '0;
      saved_seq_q     <= '0;
    end else if (step_i) begin
      send_seq_q      <= send_seq_d;
      last_rx_seq_q   <= last_rx_seq_d;
      have_rx_q       <= have_rx_d;
      ready_q         <= ready_d;
      ack_pending_q   <= ack_pending_d;
      saved_payload_q <= saved_payload_d;
      saved_seq_q     <= saved_seq_d;
    end
  end

endmodule

`default_nettype wire

[rtl/sawa_checker.sv]
// Port-level assertions for the ARQ endpoint and the bind that attaches them.
`default_nettype none

module sawa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           tx_valid_i,
  input logic [sawa_pkg::TYPE_BITS-1:0] tx_type_i,
  input logic [sawa_pkg::SEQ_BITS-1:0]  tx_seq_i,
  input logic [sawa_pkg::SEQ_BITS-1:0]  tx_ack_i,
  input logic [sawa_pkg::PL_BITS-1:0]   tx_payload_i,
  input logic [sawa_pkg::CRC_BITS-1:0]  tx_crc_i,
  input logic                           deliver_valid_i,
  input logic [sawa_pkg::PL_BITS-1:0]   deliver_payload_i,
  input logic                           send_refused_i,
  input logic [1:0]                     timer_cmd_i
);

  // A stalled result transfer keeps its payloads, its CRC and its timer command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(tx_payload_i) &&
      $stable(tx_crc_i) && $stable(deliver_payload_i) && $stable(timer_cmd_i))
    else $error("result changed while stalled");

  // Without a frame every frame field reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !tx_valid_i |-> tx_type_i == '0 && tx_seq_i == '0 &&
      tx_ack_i == '0 && tx_payload_i == '0 && tx_crc_i == '0)
    else $error("frame fields set without a frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !deliver_valid_i |-> deliver_payload_i == '0)
    else $error("delivery payload set without a delivery");

  // New data is delivered silently; its acknowledgement goes out later.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && deliver_valid_i |-> !tx_valid_i && !send_refused_i)
    else $error("delivery combined with a frame or a refusal");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && send_refused_i |-> !tx_valid_i && timer_cmd_i == sawa_pkg::TMR_NONE)
    else $error("refused send still acted on");

endmodule

bind stop_and_wait_arq_endpoint sawa_checker u_sawa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .tx_valid_i        (out_o.tx_valid),
  .tx_type_i         (out_o.tx_type),
  .tx_seq_i          (out_o.tx_seq),
  .tx_ack_i          (out_o.tx_ack),
  .tx_payload_i      (out_o.tx_payload),
  .tx_crc_i          (out_o.tx_crc),
  .deliver_valid_i   (out_o.deliver_valid),
  .deliver_payload_i (out_o.deliver_payload),
  .send_refused_i    (out_o.send_refused),
  .timer_cmd_i       (out_o.timer_cmd)
);

`default_nettype wire
